>>> src/sct_pkg.sv
`default_nettype none
package sct_pkg;

	localparam int CAPACITY   = 256;
	localparam int COORD_BITS = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = 8;
	localparam int MIN_W      = 31;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [MIN_W-1:0]      mind_t;

	typedef enum logic [2:0] {
		CMD_INSERT  = 3'd0,
		CMD_LOWER   = 3'd1,
		CMD_UPPER   = 3'd2,
		CMD_NEAREST = 3'd3,
		CMD_REMOVE  = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_CLOSE = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_NB_HI,
		S_NB_LO,
		S_NB_CHK,
		S_SHIFT,
		S_PUT,
		S_FVAL_RD,
		S_FVAL
	} state_t;

	function automatic coord_t key_of(input coord_t raw);
		return raw ^ (coord_t'(1) << (COORD_BITS - 1));
	endfunction

	function automatic logic far_above(input coord_t a, input coord_t b, input mind_t md);
		coord_t diff;
		diff = a - b;
		return (a > b) && (diff > coord_t'(md));
	endfunction

endpackage
`default_nettype wire

>>> src/sct_ram.sv
`default_nettype none
module sct_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wa,
	input  wire logic [WIDTH-1:0]         wd,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] ra,
	output      logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule
`default_nettype wire

>>> src/sorted_coordinate_table.sv
// A search alternates a read state (S_SRCH_RD) and a compare state (S_SRCH_CMP) for each halving step.
// Insert and remove move entries one per cycle through the table memory.
// One item is in work at a time; a finished result waits in the output register, and the
// next input transfer can be taken in the cycle after the result is loaded there.
// Reset clears the entry count, the minimum distance and the output valid flag.
`default_nettype none
module sorted_coordinate_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [30:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] coordinate,
	input  wire logic [7:0]  entry_index,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  status,
	output      logic [8:0]  found_index,
	output      logic [31:0] found_value,
	output      logic [8:0]  entry_count
);

	sct_pkg::state_t  state_q, state_d;
	sct_pkg::cmd_t    cmd_q;
	sct_pkg::status_t stat_q;
	sct_pkg::coord_t  raw_q, key_q, hv_q, rd;
	sct_pkg::cnt_t    lo_q, hi_q, mid_q, pos_q, cnt_q, ra_q, wa_q, mid;
	sct_pkg::mind_t   md_q;
	logic             fv_q, out_valid_q, accept, load;
	logic             ram_we, ram_re, lt, ins_ok, shift_more;
	sct_pkg::addr_t   ram_wa, ram_ra;
	sct_pkg::coord_t  ram_wd, klo, khi, up, dn;
	sct_pkg::cnt_t    idx_ext;

	sct_ram #(.DEPTH(sct_pkg::CAPACITY), .WIDTH(sct_pkg::COORD_BITS)) u_ram (
		.clk(clk), .we(ram_we), .wa(ram_wa), .wd(ram_wd), .re(ram_re), .ra(ram_ra), .rd(rd)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != sct_pkg::S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign idx_ext   = sct_pkg::cnt_t'(entry_index);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign klo       = sct_pkg::key_of(rd);
	assign khi       = sct_pkg::key_of(hv_q);
	assign up        = khi - key_q;
	assign dn        = key_q - klo;
	assign lt        = (cmd_q == sct_pkg::CMD_UPPER) ? (klo <= key_q) : (klo < key_q);
	assign ins_ok    = ((pos_q == cnt_q) || sct_pkg::far_above(khi, key_q, md_q)) &&
	                   ((pos_q == '0) || sct_pkg::far_above(key_q, klo, md_q));
	assign shift_more = (cmd_q == sct_pkg::CMD_REMOVE) ? ((ra_q + 1'b1) < cnt_q) : (ra_q > pos_q);
	assign load      = (state_q == sct_pkg::S_FVAL) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		ram_re  = 1'b0;
		ram_ra  = '0;
		ram_we  = 1'b0;
		ram_wa  = wa_q[sct_pkg::ADDR_W-1:0];
		ram_wd  = rd;
		unique case (state_q)
			sct_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						sct_pkg::CMD_INSERT, sct_pkg::CMD_LOWER, sct_pkg::CMD_UPPER:
							state_d = sct_pkg::S_SRCH_RD;
						sct_pkg::CMD_NEAREST:
							state_d = (cnt_q == '0) ? sct_pkg::S_FVAL_RD : sct_pkg::S_SRCH_RD;
						sct_pkg::CMD_REMOVE: begin
							if (idx_ext >= cnt_q || (idx_ext + 1'b1) == cnt_q) begin
								state_d = sct_pkg::S_FVAL_RD;
							end else begin
								ram_re  = 1'b1;
								ram_ra  = sct_pkg::addr_t'(idx_ext + 1'b1);
								state_d = sct_pkg::S_SHIFT;
							end
						end
						default: state_d = sct_pkg::S_FVAL_RD;
					endcase
				end
			end
			sct_pkg::S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					ram_re  = 1'b1;
					ram_ra  = mid[sct_pkg::ADDR_W-1:0];
					state_d = sct_pkg::S_SRCH_CMP;
				end else if (cmd_q == sct_pkg::CMD_INSERT || cmd_q == sct_pkg::CMD_NEAREST) begin
					state_d = sct_pkg::S_NB_HI;
				end else begin
					state_d = sct_pkg::S_FVAL_RD;
				end
			end
			sct_pkg::S_SRCH_CMP: state_d = sct_pkg::S_SRCH_RD;
			sct_pkg::S_NB_HI: begin
				ram_re  = 1'b1;
				ram_ra  = pos_q[sct_pkg::ADDR_W-1:0];
				state_d = sct_pkg::S_NB_LO;
			end
			sct_pkg::S_NB_LO: begin
				ram_re  = 1'b1;
				ram_ra  = sct_pkg::addr_t'(pos_q - 1'b1);
				state_d = sct_pkg::S_NB_CHK;
			end
			sct_pkg::S_NB_CHK: begin
				state_d = sct_pkg::S_FVAL_RD;
				if (cmd_q == sct_pkg::CMD_INSERT && ins_ok && cnt_q < sct_pkg::CAPACITY) begin
					if (pos_q == cnt_q) begin
						state_d = sct_pkg::S_PUT;
					end else begin
						ram_re  = 1'b1;
						ram_ra  = sct_pkg::addr_t'(cnt_q - 1'b1);
						state_d = sct_pkg::S_SHIFT;
					end
				end
			end
			sct_pkg::S_SHIFT: begin
				ram_we = 1'b1;
				if (shift_more) begin
					ram_re = 1'b1;
					ram_ra = (cmd_q == sct_pkg::CMD_REMOVE) ? sct_pkg::addr_t'(ra_q + 1'b1)
					                                       : sct_pkg::addr_t'(ra_q - 1'b1);
				end else begin
					state_d = (cmd_q == sct_pkg::CMD_REMOVE) ? sct_pkg::S_FVAL_RD : sct_pkg::S_PUT;
				end
			end
			sct_pkg::S_PUT: begin
				ram_we  = 1'b1;
				ram_wa  = pos_q[sct_pkg::ADDR_W-1:0];
				ram_wd  = raw_q;
				state_d = sct_pkg::S_FVAL_RD;
			end
			sct_pkg::S_FVAL_RD: begin
				ram_re  = 1'b1;
				ram_ra  = pos_q[sct_pkg::ADDR_W-1:0];
				state_d = sct_pkg::S_FVAL;
			end
			sct_pkg::S_FVAL: begin
				if (load) begin
					state_d = sct_pkg::S_IDLE;
				end
			end
			default: state_d = sct_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sct_pkg::S_IDLE;
			cnt_q       <= '0;
			md_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				md_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept && cmd == sct_pkg::CMD_CLEAR) begin
				cnt_q <= '0;
			end else if (accept && cmd == sct_pkg::CMD_REMOVE && idx_ext < cnt_q &&
			             (idx_ext + 1'b1) == cnt_q) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (state_q == sct_pkg::S_SHIFT && !shift_more &&
			             cmd_q == sct_pkg::CMD_REMOVE) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (state_q == sct_pkg::S_PUT) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sct_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q  <= sct_pkg::cmd_t'(cmd);
					raw_q  <= coordinate;
					key_q  <= sct_pkg::key_of(coordinate);
					lo_q   <= '0;
					hi_q   <= cnt_q;
					stat_q <= sct_pkg::ST_OK;
					ra_q   <= idx_ext + 1'b1;
					wa_q   <= idx_ext;
					unique case (cmd)
						sct_pkg::CMD_NEAREST: pos_q <= '0;
						sct_pkg::CMD_REMOVE: begin
							pos_q <= idx_ext;
							if (idx_ext >= cnt_q) begin
								stat_q <= sct_pkg::ST_BAD_INDEX;
							end
						end
						sct_pkg::CMD_CLEAR: pos_q <= '0;
						default: pos_q <= cnt_q;
					endcase
				end
			end
			sct_pkg::S_SRCH_RD: begin
				mid_q <= mid;
				if (!(lo_q < hi_q)) begin
					pos_q <= lo_q;
				end
			end
			sct_pkg::S_SRCH_CMP: begin
				if (lt) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			sct_pkg::S_NB_LO: hv_q <= rd;
			sct_pkg::S_NB_CHK: begin
				ra_q <= cnt_q - 1'b1;
				wa_q <= cnt_q;
				if (cmd_q == sct_pkg::CMD_INSERT) begin
					if (!ins_ok) begin
						stat_q <= sct_pkg::ST_TOO_CLOSE;
					end else if (cnt_q >= sct_pkg::CAPACITY) begin
						stat_q <= sct_pkg::ST_FULL;
					end
				end else if (pos_q == cnt_q) begin
					pos_q <= cnt_q - 1'b1;
				end else if (pos_q != '0 && !(up < dn)) begin
					pos_q <= pos_q - 1'b1;
				end
			end
			sct_pkg::S_SHIFT: begin
				if (cmd_q == sct_pkg::CMD_REMOVE) begin
					ra_q <= ra_q + 1'b1;
					wa_q <= wa_q + 1'b1;
				end else begin
					ra_q <= ra_q - 1'b1;
					wa_q <= wa_q - 1'b1;
				end
			end
			sct_pkg::S_FVAL_RD: fv_q <= (stat_q != sct_pkg::ST_BAD_INDEX) && (pos_q < cnt_q);
			sct_pkg::S_FVAL: begin
				if (load) begin
					status      <= stat_q;
					found_index <= pos_q;
					found_value <= fv_q ? rd : '0;
					entry_count <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sct_pkg::CAPACITY) else $error("entry count above capacity");

	a_put_inc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sct_pkg::S_PUT |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow the count");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_wa != ram_ra) else $error("read and write hit one entry");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == sct_pkg::S_SHIFT || state_q == sct_pkg::S_PUT))
		else $error("table write outside a move");

endmodule
`default_nettype wire
